/* hdl/rtc_tod_pkg.sv */
// Shared types, constants and helpers for the time-of-day counter.
// No dependencies.
package rtc_tod_pkg;

    localparam int FRAC_W    = 34;
    localparam int ELAPSED_W = 48;

    typedef logic [FRAC_W-1:0]    t_frac;
    typedef logic [ELAPSED_W-1:0] t_elapsed;
    typedef logic [7:0]           t_raw;
    typedef logic [5:0]           t_sixty;
    typedef logic [4:0]           t_hour;
    typedef logic [2:0]           t_wday;
    typedef logic [2:0]           t_paddr;
    typedef logic [63:0]          t_pdata;

    typedef enum logic [0:0] {
        CMD_LOAD = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    localparam t_frac  FRAC_ONE_SECOND = 34'd10000000000;
    localparam t_frac  TICK_RESET      = 34'd9765625;
    localparam t_sixty SIXTY_LAST      = 6'd59;
    localparam t_hour  HOUR_LAST       = 5'd23;
    localparam t_wday  WDAY_LAST       = 3'd7;
    localparam t_raw   PM_OFFSET       = 8'd12;
    localparam t_raw   PM_BIT          = 8'h80;

    // Any byte, also one with invalid digits: high nibble * 10 + low nibble.
    function automatic t_raw bcd_to_bin(input t_raw b);
        t_raw hi;
        hi = {4'd0, b[7:4]};
        return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
    endfunction

    function automatic t_sixty clamp_sixty(input t_raw v);
        return (v > {2'd0, SIXTY_LAST}) ? SIXTY_LAST : v[5:0];
    endfunction

endpackage

/* hdl/rtc_tick_time_of_day_counter.sv */
// Time-of-day counter: load from raw clock-chip bytes, advance on periodic ticks.
// Depends on rtc_tod_pkg.
// Path: input register, then result register; the result is registered.
// Throughput: one item per cycle while the output is not stalled; the input register
// lets a new item in while a result waits, if it is empty. Reset is synchronous: clears the time, the fraction and the
// elapsed count, and sets tick_increment to 9765625.
module rtc_tick_time_of_day_counter (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_command,
    input  logic                    i_periodic_flag,
    input  rtc_tod_pkg::t_raw       i_raw_seconds,
    input  rtc_tod_pkg::t_raw       i_raw_minutes,
    input  rtc_tod_pkg::t_raw       i_raw_hours,
    input  rtc_tod_pkg::t_raw       i_raw_weekday,
    input  logic                    i_mode_24h,
    input  logic                    i_mode_binary,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output rtc_tod_pkg::t_sixty     o_cur_seconds,
    output rtc_tod_pkg::t_sixty     o_cur_minutes,
    output rtc_tod_pkg::t_hour      o_cur_hours,
    output rtc_tod_pkg::t_wday      o_cur_weekday,
    output logic                    o_day_carry,
    output rtc_tod_pkg::t_elapsed   o_elapsed_seconds,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  rtc_tod_pkg::t_paddr     paddr,
    input  rtc_tod_pkg::t_pdata     pwdata,
    output rtc_tod_pkg::t_pdata     prdata,
    output logic                    pready
);
    import rtc_tod_pkg::*;

    // config
    t_frac r_tick_inc;
    t_frac r_inc_eff;
    logic  w_cfg_wr;

    // input register
    logic  r_in_valid;
    t_cmd  r_in_cmd;
    logic  r_in_periodic;
    t_raw  r_in_sec, r_in_min, r_in_hour, r_in_wday;
    logic  r_in_24h, r_in_bin;

    // time state
    t_frac    r_frac;
    t_sixty   r_sec, r_min;
    t_hour    r_hour;
    t_wday    r_wday;
    t_elapsed r_elapsed;

    // result register
    logic     r_out_valid;
    t_sixty   r_out_sec, r_out_min;
    t_hour    r_out_hour;
    t_wday    r_out_wday;
    logic     r_out_carry;
    t_elapsed r_out_elapsed;

    logic w_in_acc, w_out_free, w_fire;

    t_frac    n_frac;
    t_sixty   n_sec, n_min;
    t_hour    n_hour;
    t_wday    n_wday;
    t_elapsed n_elapsed;
    logic     n_carry;

    logic          w_pm;
    t_raw          w_h7, w_hb, w_h12, w_hpm;
    t_raw          w_sb, w_mb, w_wb;
    logic [FRAC_W:0] w_acc, w_acc_sub;
    logic          w_sec_carry, w_tick;
    t_wday         w_wday_inc;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = {{(64-FRAC_W){1'b0}}, r_tick_inc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_inc <= TICK_RESET;
            r_inc_eff  <= TICK_RESET;
        end else if (w_cfg_wr) begin
            r_tick_inc <= pwdata[FRAC_W-1:0];
            r_inc_eff  <= (pwdata[FRAC_W-1:0] > FRAC_ONE_SECOND) ? FRAC_ONE_SECOND
                                                                  : pwdata[FRAC_W-1:0];
        end
    end

    // handshake
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_in_acc || (r_in_valid && !w_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_cmd      <= t_cmd'(i_command);
            r_in_periodic <= i_periodic_flag;
            r_in_sec      <= i_raw_seconds;
            r_in_min      <= i_raw_minutes;
            r_in_hour     <= i_raw_hours;
            r_in_wday     <= i_raw_weekday;
            r_in_24h      <= i_mode_24h;
            r_in_bin      <= i_mode_binary;
        end
    end

    // load path
    always_comb begin
        w_pm  = !r_in_24h && ((r_in_hour & PM_BIT) != 8'd0);
        w_h7  = r_in_24h ? r_in_hour : (r_in_hour & ~PM_BIT);
        w_hb  = r_in_bin ? w_h7      : bcd_to_bin(w_h7);
        w_sb  = r_in_bin ? r_in_sec  : bcd_to_bin(r_in_sec);
        w_mb  = r_in_bin ? r_in_min  : bcd_to_bin(r_in_min);
        w_wb  = r_in_bin ? r_in_wday : bcd_to_bin(r_in_wday);
        w_h12 = (!r_in_24h && (w_hb == PM_OFFSET)) ? 8'd0 : w_hb;
        w_hpm = w_pm ? (w_h12 + PM_OFFSET) : w_h12;
    end

    // tick path
    always_comb begin
        w_tick      = (r_in_cmd == CMD_TICK) && r_in_periodic;
        w_acc       = {1'b0, r_frac} + {1'b0, r_inc_eff};
        w_acc_sub   = w_acc - {1'b0, FRAC_ONE_SECOND};
        w_sec_carry = (w_acc >= {1'b0, FRAC_ONE_SECOND});
        case (r_wday)
            3'd6:    w_wday_inc = 3'd0;
            3'd7:    w_wday_inc = 3'd1;
            default: w_wday_inc = r_wday + 3'd1;
        endcase
    end

    always_comb begin
        n_frac    = r_frac;
        n_sec     = r_sec;
        n_min     = r_min;
        n_hour    = r_hour;
        n_wday    = r_wday;
        n_elapsed = r_elapsed;
        n_carry   = 1'b0;
        if (r_in_cmd == CMD_LOAD) begin
            n_sec  = clamp_sixty(w_sb);
            n_min  = clamp_sixty(w_mb);
            n_hour = (w_hpm > {3'd0, HOUR_LAST}) ? HOUR_LAST : w_hpm[4:0];
            n_wday = (w_wb > {5'd0, WDAY_LAST}) ? WDAY_LAST : w_wb[2:0];
        end else if (w_tick) begin
            n_frac = w_sec_carry ? w_acc_sub[FRAC_W-1:0] : w_acc[FRAC_W-1:0];
            if (w_sec_carry) begin
                n_elapsed = r_elapsed + 48'd1;
                if (r_sec >= SIXTY_LAST) begin
                    n_sec = 6'd0;
                    if (r_min >= SIXTY_LAST) begin
                        n_min = 6'd0;
                        if (r_hour >= HOUR_LAST) begin
                            n_hour  = 5'd0;
                            n_wday  = w_wday_inc;
                            n_carry = 1'b1;
                        end else begin
                            n_hour = r_hour + 5'd1;
                        end
                    end else begin
                        n_min = r_min + 6'd1;
                    end
                end else begin
                    n_sec = r_sec + 6'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac    <= '0;
            r_sec     <= '0;
            r_min     <= '0;
            r_hour    <= '0;
            r_wday    <= '0;
            r_elapsed <= '0;
        end else if (w_fire) begin
            r_frac    <= n_frac;
            r_sec     <= n_sec;
            r_min     <= n_min;
            r_hour    <= n_hour;
            r_wday    <= n_wday;
            r_elapsed <= n_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_sec     <= n_sec;
            r_out_min     <= n_min;
            r_out_hour    <= n_hour;
            r_out_wday    <= n_wday;
            r_out_carry   <= n_carry;
            r_out_elapsed <= n_elapsed;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_cur_seconds     = r_out_sec;
    assign o_cur_minutes     = r_out_min;
    assign o_cur_hours       = r_out_hour;
    assign o_cur_weekday     = r_out_wday;
    assign o_day_carry       = r_out_carry;
    assign o_elapsed_seconds = r_out_elapsed;

    a_frac_below_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frac < FRAC_ONE_SECOND)
        else $error("fraction accumulator reached one second");

    a_carry_at_midnight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_day_carry) |->
        (o_cur_hours == 5'd0 && o_cur_minutes == 6'd0 && o_cur_seconds == 6'd0))
        else $error("day carry without midnight");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_fire) |=> r_in_valid)
        else $error("input item dropped while stalled");

    a_elapsed_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !w_tick) |=> (r_elapsed == $past(r_elapsed)))
        else $error("elapsed count moved without a tick");

endmodule
